[rtl/x86_alu_with_flag_tracking_core_macros.svh]
// Assertion macros for the flag-tracking ALU checker.
`ifndef X86_ALU_WITH_FLAG_TRACKING_CORE_MACROS_SVH
`define X86_ALU_WITH_FLAG_TRACKING_CORE_MACROS_SVH
// Implication, disabled while reset is high.
`define XAF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define XAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/xaf_pkg.sv]
// ----------------------------------------------------------------------------
// xaf_pkg
// Shared types and opcode codes for the flag-tracking integer ALU.
// ----------------------------------------------------------------------------
package xaf_pkg;
  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_ADC = 5'd1, OP_CMP = 5'd2, OP_SUB = 5'd3, OP_SBB = 5'd4,
    OP_TEST = 5'd5, OP_AND = 5'd6, OP_OR = 5'd7, OP_XOR = 5'd8, OP_SETCC = 5'd9,
    OP_CMOV = 5'd10, OP_SHR = 5'd11, OP_SAR = 5'd12, OP_SHL = 5'd13,
    OP_ROL = 5'd14, OP_ROR = 5'd15, OP_MOV = 5'd16, OP_CBW = 5'd17,
    OP_CWDE = 5'd18, OP_CDQE = 5'd19, OP_CWD = 5'd20, OP_CDQ = 5'd21,
    OP_CQO = 5'd22, OP_NOT = 5'd23, OP_NEG = 5'd24, OP_BT = 5'd25,
    OP_BTR = 5'd26, OP_BTC = 5'd27, OP_BTS = 5'd28, OP_BSWAP = 5'd29,
    OP_RSV30 = 5'd30, OP_RSV31 = 5'd31
  } op_t;

  localparam int FC = 0;
  localparam int FP = 1;
  localparam int FA = 2;
  localparam int FZ = 3;
  localparam int FS = 4;
  localparam int FO = 5;
  localparam logic [5:0] CM_LT = 6'h30;
  localparam logic [5:0] CM_LE = 6'h38;

  // Decoded item handed from front to back.
  typedef struct packed {
    op_t         op;
    logic [1:0]  size;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  cmask;
    logic        inv;
    logic [63:0] vmask;
    logic [63:0] sign;
    logic [5:0]  cnt;
    logic        cnt_zero;
  } uop_t;

  typedef struct packed {
    logic [63:0] value;
    logic        wb;
    logic [5:0]  fv;
    logic [5:0]  fk;
    logic        fault;
  } res_t;
endpackage

[rtl/x86_alu_with_flag_tracking_core.sv]
// Path: an accepted input is queued in the front end, then registered in the back end, raising m_tvalid.
// Throughput: one item per cycle while m_tready holds; flags feed back through one register in the back end.
// Input and output stall independently through a two-entry queue.
// Reset (rst, synchronous): clears flags, known mask, queue and output valid.
// ----------------------------------------------------------------------------
// x86_alu_with_flag_tracking_core
// Integer ALU with x86-style flag tracking, stream in and stream out.
// ----------------------------------------------------------------------------
module x86_alu_with_flag_tracking_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // cmd[4:0], data_size[6:5], operand_a[70:7], operand_b[134:71],
  // cond_mask[140:135], invert[141], zero pad
  input  logic [143:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // result_value[63:0], write_back[64], flag_values[70:65], flag_known[76:71],
  // fault[77], zero pad
  output logic [79:0]   m_tdata
);
  logic          q_valid, q_ready;
  xaf_pkg::uop_t q_data;
  xaf_pkg::res_t r;

  xaf_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .cmd(s_tdata[4:0]), .data_size(s_tdata[6:5]),
    .operand_a(s_tdata[70:7]), .operand_b(s_tdata[134:71]),
    .cond_mask(s_tdata[140:135]), .invert(s_tdata[141]),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  xaf_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(r)
  );

  assign m_tdata = {2'b00, r.fault, r.fk, r.fv, r.wb, r.value};
endmodule

[rtl/xaf_front.sv]
// ----------------------------------------------------------------------------
// xaf_front
// Accepts items, decodes size masks and counts into a two-entry queue.
// ----------------------------------------------------------------------------
module xaf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [4:0]        cmd,
  input  logic [1:0]        data_size,
  input  logic [63:0]       operand_a,
  input  logic [63:0]       operand_b,
  input  logic [5:0]        cond_mask,
  input  logic              invert,
  output logic              q_valid,
  input  logic              q_ready,
  output xaf_pkg::uop_t     q_data
);
  xaf_pkg::uop_t slot [2];
  logic [1:0] cnt;
  logic       rd;
  logic       wr_ptr;
  xaf_pkg::uop_t u;
  logic push, pop;

  always_comb begin
    u.op    = xaf_pkg::op_t'(cmd);
    u.size  = data_size;
    u.a     = operand_a;
    u.b     = operand_b;
    u.cmask = cond_mask;
    u.inv   = invert;
    case (data_size)
      2'd0:    u.vmask = 64'h0000_0000_0000_00ff;
      2'd1:    u.vmask = 64'h0000_0000_0000_ffff;
      2'd2:    u.vmask = 64'h0000_0000_ffff_ffff;
      default: u.vmask = 64'hffff_ffff_ffff_ffff;
    endcase
    u.sign = u.vmask ^ {1'b0, u.vmask[63:1]};
    u.cnt  = (data_size == 2'd3) ? operand_b[5:0] : {1'b0, operand_b[4:0]};
    u.cnt_zero = (u.cnt == 6'd0);
  end

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_data   = slot[rd];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      rd <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd <= ~rd;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= u;
  end
endmodule

[rtl/xaf_back.sv]
// ----------------------------------------------------------------------------
// xaf_back
// Executes one decoded item per cycle while the output is not stalled, holds the flags, registers the result.
// ----------------------------------------------------------------------------
module xaf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  xaf_pkg::uop_t     q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output xaf_pkg::res_t     out_data
);
  logic [5:0] flag_bits, flag_valid_mask;
  xaf_pkg::res_t res;
  logic go;

  assign q_ready = !out_valid || out_ready;
  assign go = q_valid && q_ready;

  always_comb begin
    logic [63:0] a, b, vm, sg, am, r, t, ext, sh;
    logic [5:0]  fv, fk, n, k, nm1, wm1;
    logic        cin, wr, ok, flt, zs, cond, z, s, o, sb;
    a = q_data.a; b = q_data.b; vm = q_data.vmask; sg = q_data.sign;
    am = a & vm;
    fv = flag_bits; fk = flag_valid_mask;
    r = 64'd0; wr = 1'b1; ok = 1'b1; flt = 1'b0; zs = 1'b0;
    n = q_data.cnt; nm1 = n - 6'd1;
    wm1 = vm[63] ? 6'd63 : vm[31] ? 6'd31 : vm[15] ? 6'd15 : 6'd7;
    k = n & wm1;
    sb = |(a & sg);
    ext = sb ? (a | ~vm) : am;
    t = 64'd0; sh = 64'd0;
    z = flag_bits[xaf_pkg::FZ]; s = flag_bits[xaf_pkg::FS];
    o = flag_bits[xaf_pkg::FO];
    if (q_data.cmask == xaf_pkg::CM_LT) cond = s ^ o;
    else if (q_data.cmask == xaf_pkg::CM_LE) cond = z | (s ^ o);
    else cond = |(flag_bits & q_data.cmask);
    cond = cond ^ q_data.inv;
    cin = 1'b0;
    case (q_data.op)
      xaf_pkg::OP_ADD, xaf_pkg::OP_ADC: begin
        cin = (q_data.op == xaf_pkg::OP_ADC) && flag_bits[xaf_pkg::FC];
        r = a + b + {63'd0, cin};
        fv = 6'd0; fk = 6'b100001;
        fv[xaf_pkg::FC] = cin ? ((r & vm) <= am) : ((r & vm) < am);
        fv[xaf_pkg::FO] = |((~(a ^ b) & (b ^ r)) & sg);
        zs = 1'b1;
      end
      xaf_pkg::OP_CMP, xaf_pkg::OP_SUB, xaf_pkg::OP_SBB: begin
        cin = (q_data.op == xaf_pkg::OP_SBB) && flag_bits[xaf_pkg::FC];
        r = a - b - {63'd0, cin};
        fv = 6'd0; fk = 6'b100001;
        fv[xaf_pkg::FC] = cin ? (am <= (r & vm)) : (am < (b & vm));
        fv[xaf_pkg::FO] = |(((a ^ b) & (a ^ r)) & sg);
        zs = 1'b1;
        wr = (q_data.op != xaf_pkg::OP_CMP);
      end
      xaf_pkg::OP_TEST, xaf_pkg::OP_AND, xaf_pkg::OP_OR, xaf_pkg::OP_XOR: begin
        r = (q_data.op == xaf_pkg::OP_OR) ? (a | b) :
            (q_data.op == xaf_pkg::OP_XOR) ? (a ^ b) : (a & b);
        fv = 6'd0; fk = 6'b100001;
        zs = 1'b1;
        wr = (q_data.op != xaf_pkg::OP_TEST);
      end
      xaf_pkg::OP_SETCC: r = {63'd0, cond};
      xaf_pkg::OP_CMOV: begin
        r = b;
        ok = cond;
      end
      xaf_pkg::OP_SHR, xaf_pkg::OP_SAR, xaf_pkg::OP_SHL: begin
        ok = !q_data.cnt_zero;
        fv = 6'd0; fk = 6'b000001; zs = 1'b1;
        if (q_data.op == xaf_pkg::OP_SHR) begin
          r = am >> n;
          sh = am >> nm1;
          fv[xaf_pkg::FC] = sh[0];
          if (n == 6'd1) begin
            fk[xaf_pkg::FO] = 1'b1; fv[xaf_pkg::FO] = sb;
          end
        end else if (q_data.op == xaf_pkg::OP_SAR) begin
          r = 64'($signed(ext) >>> n);
          sh = 64'($signed(ext) >>> nm1);
          fv[xaf_pkg::FC] = sh[0];
          if (n == 6'd1) fk[xaf_pkg::FO] = 1'b1;
        end else begin
          r = am << n;
          sh = am << nm1;
          fv[xaf_pkg::FC] = |(sh & sg);
          if (n == 6'd1) begin
            fk[xaf_pkg::FO] = 1'b1;
            fv[xaf_pkg::FO] = (|(r & sg)) ^ fv[xaf_pkg::FC];
          end
        end
      end
      xaf_pkg::OP_ROL, xaf_pkg::OP_ROR: begin
        ok = !q_data.cnt_zero;
        fv[xaf_pkg::FC] = 1'b0; fv[xaf_pkg::FO] = 1'b0;
        fk[xaf_pkg::FC] = 1'b1; fk[xaf_pkg::FO] = 1'b0;
        // Rotate as the OR of two opposite shifts of the sized value.
        if (q_data.op == xaf_pkg::OP_ROL) begin
          t = am >> (7'd1 + {1'b0, wm1} - {1'b0, k});
          r = k == 6'd0 ? am : (((am << k) | t) & vm);
          fv[xaf_pkg::FC] = r[0];
          if (n == 6'd1) begin
            fk[xaf_pkg::FO] = 1'b1;
            fv[xaf_pkg::FO] = (|(r & sg)) ^ r[0];
          end
        end else begin
          t = am << (7'd1 + {1'b0, wm1} - {1'b0, k});
          r = k == 6'd0 ? am : (((am >> k) | t) & vm);
          fv[xaf_pkg::FC] = |(r & sg);
          if (n == 6'd1) begin
            fk[xaf_pkg::FO] = 1'b1;
            fv[xaf_pkg::FO] = (|(r & sg)) ^ (|((r << 1) & sg));
          end
        end
      end
      xaf_pkg::OP_MOV:  r = b;
      xaf_pkg::OP_CBW:  r = {{56{b[7]}}, b[7:0]};
      xaf_pkg::OP_CWDE: r = {{48{b[15]}}, b[15:0]};
      xaf_pkg::OP_CDQE: r = {{32{b[31]}}, b[31:0]};
      xaf_pkg::OP_CWD:  r = {64{b[15]}};
      xaf_pkg::OP_CDQ:  r = {64{b[31]}};
      xaf_pkg::OP_CQO:  r = {64{b[63]}};
      xaf_pkg::OP_NOT:  r = ~a;
      xaf_pkg::OP_NEG: begin
        r = 64'd0 - a;
        fv = 6'd0; fk = 6'b100001;
        fv[xaf_pkg::FC] = |(r & vm);
        fv[xaf_pkg::FO] = ((r & vm) == sg);
        zs = 1'b1;
      end
      xaf_pkg::OP_BT, xaf_pkg::OP_BTR, xaf_pkg::OP_BTC, xaf_pkg::OP_BTS: begin
        k = b[5:0] & wm1;
        t = 64'd1 << k;
        r = (q_data.op == xaf_pkg::OP_BT)  ? a :
            (q_data.op == xaf_pkg::OP_BTR) ? (a & ~t) :
            (q_data.op == xaf_pkg::OP_BTC) ? (a ^ t) : (a | t);
        fv = fv & 6'b001000; fk = fk & 6'b001000;
        fk[xaf_pkg::FC] = 1'b1;
        fv[xaf_pkg::FC] = |(a & t);
        wr = (q_data.op != xaf_pkg::OP_BT);
      end
      xaf_pkg::OP_BSWAP: begin
        if (q_data.size == 2'd2)
          r = {32'd0, a[7:0], a[15:8], a[23:16], a[31:24]};
        else if (q_data.size == 2'd3)
          r = {a[7:0], a[15:8], a[23:16], a[31:24],
               a[39:32], a[47:40], a[55:48], a[63:56]};
        else begin
          ok = 1'b0; flt = 1'b1;
        end
      end
      default: begin
        ok = 1'b0; flt = 1'b1;
      end
    endcase
    if (zs) begin
      fk[xaf_pkg::FZ] = 1'b1; fk[xaf_pkg::FS] = 1'b1;
      fv[xaf_pkg::FZ] = ((r & vm) == 64'd0);
      fv[xaf_pkg::FS] = |(r & sg);
    end
    if (!ok) begin
      wr = 1'b0; fv = flag_bits; fk = flag_valid_mask;
    end
    res.value = wr ? ((a & ~vm) | (r & vm)) : a;
    res.wb    = wr;
    res.fv    = fv;
    res.fk    = fk;
    res.fault = flt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_bits <= 6'd0;
      flag_valid_mask <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      if (go) begin
        flag_bits <= res.fv;
        flag_valid_mask <= res.fk;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) out_data <= res;
  end
endmodule

[rtl/xaf_checker.sv]
// ----------------------------------------------------------------------------
// xaf_checker
// Port-level checks of the flag-tracking ALU.
// ----------------------------------------------------------------------------
`include "x86_alu_with_flag_tracking_core_macros.svh"
module xaf_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [143:0] s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [79:0]  m_tdata
);
  `XAF_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "out held")
  `XAF_ASSERT_IMP(a_fault_nowb, m_tvalid && m_tdata[77], !m_tdata[64], "fault with write back")
  `XAF_ASSERT_IMP(a_val_known, m_tvalid, (m_tdata[70:65] & ~m_tdata[76:71]) == 6'd0, "flag set")
  `XAF_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata), "in held")
endmodule

bind x86_alu_with_flag_tracking_core xaf_checker u_xaf_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the flag-tracking ALU: a queue-fed driver, a monitor
// checking each result against an in-bench model of the ALU and its flags.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic [4:0]  cmd;
    logic [1:0]  size;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  cmask;
    logic        inv;
  } alu_item_t;

  typedef struct {
    logic [63:0] value;
    logic        wb;
    logic [5:0]  fv;
    logic [5:0]  fk;
    logic        fault;
  } alu_res_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [143:0]  s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [79:0]   m_tdata;

  alu_item_t pending_items[$];
  alu_res_t  expected_results[$];
  logic [5:0] model_flags = '0;
  logic [5:0] model_known = '0;
  int errors = 0;
  int stall_cycles = 0;
  bit calm = 0;
  bit hold_off = 0;
  bit stim_done = 0;
  int send_gap = 0;
  int recv_gap = 0;

  x86_alu_with_flag_tracking_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] sext(logic [63:0] x, int bits);
    logic [63:0] m;
    if (bits >= 64) return x;
    m = (64'd1 << bits) - 64'd1;
    x &= m;
    if (x[bits-1]) x |= ~m;
    return x;
  endfunction

  function automatic logic [63:0] asr(logic [63:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic bit cond_true(logic [5:0] f, logic [5:0] cm);
    if (cm == xaf_pkg::CM_LT) return f[xaf_pkg::FS] != f[xaf_pkg::FO];
    if (cm == xaf_pkg::CM_LE)
      return f[xaf_pkg::FZ] || (f[xaf_pkg::FS] != f[xaf_pkg::FO]);
    return (f & cm) != 0;
  endfunction

  // Executes one item on the model flags and returns the result.
  function automatic alu_res_t alu_execute(alu_item_t it);
    alu_res_t res;
    int w;
    logic [63:0] sign, vm, am, r, t, a, b;
    logic [5:0] fv, fk, pv;
    int n, k;
    bit wr, ok, flt, zs, cin;
    xaf_pkg::op_t op;
    a = it.a; b = it.b;
    w = 8 << it.size;
    sign = 64'd1 << (w - 1);
    vm = sign | (sign - 64'd1);
    am = a & vm;
    pv = model_flags; fv = model_flags; fk = model_known;
    r = '0; wr = 1; ok = 1; flt = 0; zs = 0;
    op = xaf_pkg::op_t'(it.cmd);
    case (op)
      xaf_pkg::OP_ADD, xaf_pkg::OP_ADC: begin
        cin = (op == xaf_pkg::OP_ADC) && pv[xaf_pkg::FC];
        r = a + b + {63'd0, cin};
        fv = '0; fk = 6'b100001;
        if (cin ? ((r & vm) <= am) : ((r & vm) < am)) fv[xaf_pkg::FC] = 1;
        if ((~(a ^ b) & (b ^ r) & sign) != 0) fv[xaf_pkg::FO] = 1;
        zs = 1;
      end
      xaf_pkg::OP_CMP, xaf_pkg::OP_SUB, xaf_pkg::OP_SBB: begin
        cin = (op == xaf_pkg::OP_SBB) && pv[xaf_pkg::FC];
        r = a - b - {63'd0, cin};
        fv = '0; fk = 6'b100001;
        if (cin ? (am <= (r & vm)) : (am < (b & vm))) fv[xaf_pkg::FC] = 1;
        if (((a ^ b) & (a ^ r) & sign) != 0) fv[xaf_pkg::FO] = 1;
        zs = 1;
        wr = (op != xaf_pkg::OP_CMP);
      end
      xaf_pkg::OP_TEST, xaf_pkg::OP_AND, xaf_pkg::OP_OR, xaf_pkg::OP_XOR: begin
        r = (op == xaf_pkg::OP_OR) ? (a | b) : (op == xaf_pkg::OP_XOR) ? (a ^ b) : (a & b);
        fv = '0; fk = 6'b100001;
        zs = 1;
        wr = (op != xaf_pkg::OP_TEST);
      end
      xaf_pkg::OP_SETCC: r = (cond_true(pv, it.cmask) != it.inv) ? 64'd1 : 64'd0;
      xaf_pkg::OP_CMOV: if (cond_true(pv, it.cmask) != it.inv) r = b; else ok = 0;
      xaf_pkg::OP_SHR, xaf_pkg::OP_SAR, xaf_pkg::OP_SHL, xaf_pkg::OP_ROL,
      xaf_pkg::OP_ROR: begin
        n = (it.size == 3) ? int'(b[5:0]) : int'(b[4:0]);
        if (n == 0) ok = 0;
        else begin
          if (op inside {xaf_pkg::OP_SHR, xaf_pkg::OP_SAR, xaf_pkg::OP_SHL}) begin
            fv = '0; fk = 6'b000001; zs = 1;
          end else begin
            fv[xaf_pkg::FC] = 0; fv[xaf_pkg::FO] = 0;
            fk[xaf_pkg::FC] = 1; fk[xaf_pkg::FO] = 0;
          end
          case (op)
            xaf_pkg::OP_SHR: begin
              r = am >> n;
              fv[xaf_pkg::FC] = am[n-1];
              if (n == 1) begin
                fk[xaf_pkg::FO] = 1; fv[xaf_pkg::FO] = (a & sign) != 0;
              end
            end
            xaf_pkg::OP_SAR: begin
              t = sext(a, w);
              r = asr(t, n);
              fv[xaf_pkg::FC] = (asr(t, n - 1) & 64'd1) != 0;
              if (n == 1) fk[xaf_pkg::FO] = 1;
            end
            xaf_pkg::OP_SHL: begin
              r = am << n;
              fv[xaf_pkg::FC] = ((am << (n - 1)) & sign) != 0;
              if (n == 1) begin
                fk[xaf_pkg::FO] = 1;
                fv[xaf_pkg::FO] = ((r & sign) != 0) != fv[xaf_pkg::FC];
              end
            end
            default: begin
              k = n & (w - 1);
              if (k == 0) r = am;
              else if (op == xaf_pkg::OP_ROL) r = ((am << k) | (am >> (w - k))) & vm;
              else r = ((am >> k) | (am << (w - k))) & vm;
              if (op == xaf_pkg::OP_ROL) begin
                fv[xaf_pkg::FC] = r[0];
                if (n == 1) begin
                  fk[xaf_pkg::FO] = 1;
                  fv[xaf_pkg::FO] = ((r & sign) != 0) != fv[xaf_pkg::FC];
                end
              end else begin
                fv[xaf_pkg::FC] = (r & sign) != 0;
                if (n == 1) begin
                  fk[xaf_pkg::FO] = 1;
                  fv[xaf_pkg::FO] = ((r & sign) != 0) != (((r << 1) & sign) != 0);
                end
              end
            end
          endcase
        end
      end
      xaf_pkg::OP_MOV: r = b;
      xaf_pkg::OP_CBW: r = sext(b, 8);
      xaf_pkg::OP_CWDE: r = sext(b, 16);
      xaf_pkg::OP_CDQE: r = sext(b, 32);
      xaf_pkg::OP_CWD: r = b[15] ? '1 : '0;
      xaf_pkg::OP_CDQ: r = b[31] ? '1 : '0;
      xaf_pkg::OP_CQO: r = b[63] ? '1 : '0;
      xaf_pkg::OP_NOT: r = ~a;
      xaf_pkg::OP_NEG: begin
        r = 64'd0 - a;
        fv = '0; fk = 6'b100001;
        fv[xaf_pkg::FC] = (r & vm) != 0;
        fv[xaf_pkg::FO] = (r & vm) == sign;
        zs = 1;
      end
      xaf_pkg::OP_BT, xaf_pkg::OP_BTR, xaf_pkg::OP_BTC, xaf_pkg::OP_BTS: begin
        n = int'(b[5:0]) & (w - 1);
        t = 64'd1 << n;
        r = (op == xaf_pkg::OP_BT) ? a : (op == xaf_pkg::OP_BTR) ? (a & ~t) :
            (op == xaf_pkg::OP_BTC) ? (a ^ t) : (a | t);
        fv &= 6'b001000; fk &= 6'b001000; fk[xaf_pkg::FC] = 1;
        fv[xaf_pkg::FC] = a[n];
        wr = (op != xaf_pkg::OP_BT);
      end
      xaf_pkg::OP_BSWAP: begin
        if (it.size == 2) r = {32'd0, a[7:0], a[15:8], a[23:16], a[31:24]};
        else if (it.size == 3) r = {<<8{a}};
        else begin ok = 0; flt = 1; end
      end
      default: begin ok = 0; flt = 1; end
    endcase
    if (zs) begin
      fk[xaf_pkg::FZ] = 1; fk[xaf_pkg::FS] = 1;
      fv[xaf_pkg::FZ] = (r & vm) == 0;
      fv[xaf_pkg::FS] = (r & sign) != 0;
    end
    if (!ok) wr = 0;
    else begin
      model_flags = fv; model_known = fk;
    end
    res.value = wr ? ((a & ~vm) | (r & vm)) : a;
    res.wb = wr;
    res.fv = model_flags;
    res.fk = model_known;
    res.fault = flt;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = 64'd1 << $urandom_range(0, 63);
      3: v = 64'($urandom_range(0, 70));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic push_item(int cmd, int size, logic [63:0] a, logic [63:0] b,
                           int cm, int inv);
    alu_item_t it;
    it.cmd = 5'(cmd); it.size = 2'(size); it.a = a; it.b = b;
    it.cmask = 6'(cm); it.inv = 1'(inv);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Driver
  always @(posedge clk) begin
    alu_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        it = pending_items.pop_front();
        expected_results.insert(expected_results.size(), alu_execute(it));
      end
      if (!(s_tvalid && !s_tready)) begin
        if (send_gap > 0) send_gap--;
        if (pending_items.size() > 0 && send_gap == 0 && !hold_off
            && !(s_tvalid && s_tready && pending_items.size() == 0)) begin
          if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
          end else begin
            it = pending_items[0];
            s_tdata <= {2'b00, it.inv, it.cmask, it.b, it.a, it.size, it.cmd};
            s_tvalid <= 1'b1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    alu_res_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", m_tdata[63:0], 0);
        end else begin
          e = expected_results.pop_front();
          if (m_tdata[63:0] !== e.value) report_mismatch("result_value", m_tdata[63:0], e.value);
          if (m_tdata[64] !== e.wb) report_mismatch("write_back", m_tdata[64], e.wb);
          if (m_tdata[70:65] !== e.fv) report_mismatch("flag_values", m_tdata[70:65], e.fv);
          if (m_tdata[76:71] !== e.fk) report_mismatch("flag_known", m_tdata[76:71], e.fk);
          if (m_tdata[77] !== e.fault) report_mismatch("fault", m_tdata[77], e.fault);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 13);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles > 2000) begin
        $display("timeout");
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int cmd, sz;
    logic [63:0] a, b;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // directed: opcodes 0 to 24 at one size each, on edge values
    for (cmd = 0; cmd < 32; cmd++) begin
      sz = cmd % 4;
      push_item(cmd, sz, 64'h8000_0000_0000_0080, (cmd % 3 == 0) ? 64'd1 : '1,
                (cmd % 2) ? xaf_pkg::CM_LT : xaf_pkg::CM_LE, cmd % 2);
      if (cmd >= 24) break;
    end
    push_item(xaf_pkg::OP_BSWAP, 0, 64'h0123_4567_89ab_cdef, 0, 0, 0);
    push_item(xaf_pkg::OP_BSWAP, 1, 64'h0123_4567_89ab_cdef, 0, 0, 0);
    push_item(xaf_pkg::OP_BSWAP, 2, 64'h0123_4567_89ab_cdef, 0, 0, 0);
    push_item(xaf_pkg::OP_BSWAP, 3, 64'h0123_4567_89ab_cdef, 0, 0, 0);
    push_item(xaf_pkg::OP_RSV30, 3, '1, '1, 6'h3f, 1);
    push_item(xaf_pkg::OP_RSV31, 0, '0, '0, 0, 0);
    push_item(xaf_pkg::OP_SHL, 1, 64'hffff, 64'd32, 0, 0);
    push_item(xaf_pkg::OP_CMOV, 3, '0, '1, 6'h00, 0);
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    // hold the sender idle after the block has drained
    hold_off = 1;
    repeat (5) @(posedge clk);
    hold_off = 0;
    for (int i = 0; i < 1800; i++) begin
      if (i == 1500) begin
        wait (pending_items.size() == 0);
        calm = 1;
      end
      cmd = ($urandom_range(0, 30) == 0) ? $urandom_range(30, 31) : $urandom_range(0, 29);
      a = rand64();
      b = rand64();
      if (cmd >= xaf_pkg::OP_SHR && cmd <= xaf_pkg::OP_ROR && $urandom_range(0, 1))
        b = 64'($urandom_range(0, 70));
      push_item(cmd, $urandom_range(0, 3), a, b,
                $urandom_range(0, 2) ? $urandom_range(0, 63)
                                     : ($urandom_range(0, 1) ? xaf_pkg::CM_LT
                                                             : xaf_pkg::CM_LE),
                $urandom_range(0, 1));
    end
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
